// File: hw/rtl/assert_macros.svh
// assertion macros used by the psg tone and noise generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/psg_pkg.sv
// package with payload types, opcodes and constants of the psg tone and noise generator
package psg_pkg;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [1:0] CSR_SAMPLE_PERIOD = 2'd0;
   localparam logic [1:0] CSR_SHORT_NOISE   = 2'd1;
   localparam logic [1:0] CSR_NOISE_TAPS    = 2'd2;

   localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd81;
   localparam logic [15:0] SAMPLE_PERIOD_MIN   = 16'd16;
   localparam logic [15:0] NOISE_TAPS_RESET    = 16'h0009;
   localparam logic [15:0] LFSR_SEED           = 16'h8000;
   localparam logic [9:0]  MIN_TONE_RUN        = 10'd8;
   localparam logic [16:0] TICK_CYCLES         = 17'd16;
   localparam int          NUM_TONES           = 3;
   localparam int          NOISE_CHANNEL       = 3;

   typedef struct packed {
      logic       op;
      logic [7:0] write_byte;
   } req_data_type;

   typedef struct packed {
      logic [3:0] tone0_level;
      logic [3:0] tone1_level;
      logic [3:0] tone2_level;
      logic [3:0] noise_level;
   } rsp_data_type;

endpackage

// File: hw/rtl/psg_tone_noise_generator.sv
// top level of the psg tone and noise generator
// three square-tone channels and one noise channel in the classic psg register scheme.
// a req transaction is either a register byte (op write) or a tick of cpu time (op tick).
// the channel state registers update at the accepting edge and a tick that completes a
// sample period loads the rsp output register with the four channel levels, so one
// transaction can be accepted per cycle and rsp_valid rises in the cycle after the
// accepting one. the single rsp output register is the only thing that can hold back
// the input: a tick that would emit a sample waits while an earlier sample sits
// unaccepted, while writes and silent ticks keep flowing. the csr port sets the sample
// period (values below 16 act as 16), the short noise period select and the white noise
// tap mask; it must be written while the block is idle, which the block does not enforce.
`include "assert_macros.svh"

module psg_tone_noise_generator import psg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   // configuration registers
   logic [15:0] sample_period_ff;
   logic        short_noise_ff;
   logic [15:0] noise_taps_ff;

   // channel state
   logic [3:0]        atten_ff    [4];
   logic [3:0]        atten_in    [4];
   logic [9:0]        tone_per_ff [NUM_TONES];
   logic [9:0]        tone_per_in [NUM_TONES];
   logic signed [15:0] tone_cd_ff [NUM_TONES];
   logic signed [15:0] tone_cd_in [NUM_TONES];
   logic [3:0]        chan_pol_ff;
   logic [3:0]        chan_pol_in;
   logic [1:0]        latch_ch_ff;
   logic [1:0]        latch_ch_in;
   logic              latch_vol_ff;
   logic              latch_vol_in;
   logic [15:0]       noise_shift_ff;
   logic [15:0]       noise_shift_in;
   logic              noise_white_ff;
   logic              noise_white_in;
   logic [1:0]        noise_rate_ff;
   logic [1:0]        noise_rate_in;
   logic signed [15:0] noise_cd_ff;
   logic signed [15:0] noise_cd_in;
   logic              noise_tog_ff;
   logic              noise_tog_in;
   logic [16:0]       accum_ff;
   logic [16:0]       accum_in;

   // output register
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_data_in;

   // handshake and decode
   logic        req_accept;
   logic        is_tick;
   logic        is_write;
   logic        emit;
   logic [15:0] period_eff;
   logic [16:0] accum_sum;

   // write decode
   logic       byte_latch;
   logic [1:0] wr_ch;
   logic       wr_vol;
   logic [5:0] wr_data;

   // noise step helpers
   logic signed [16:0] noise_sub;
   logic signed [15:0] noise_sat;
   logic signed [15:0] noise_reload;
   logic               noise_fire;
   logic               lfsr_top;

   // tone step helpers
   logic               tone_pos  [NUM_TONES];
   logic               tone_run  [NUM_TONES];
   logic signed [15:0] tone_dec  [NUM_TONES];
   logic signed [15:0] tone_load [NUM_TONES];

   assign is_tick  = (req_data.op == OP_TICK);
   assign is_write = (req_data.op == OP_WRITE);

   // sample pacing: one sample at most per tick
   assign period_eff = (sample_period_ff < SAMPLE_PERIOD_MIN) ? SAMPLE_PERIOD_MIN
                                                              : sample_period_ff;
   assign accum_sum  = accum_ff + TICK_CYCLES;
   assign emit       = is_tick && (accum_sum >= {1'b0, period_eff});

   // only a sample-producing tick needs the output register free
   assign req_ready  = !rsp_valid_ff || rsp_ready || !emit;
   assign req_accept = req_valid && req_ready;

   // a latch byte names channel and type, a data byte reuses the latched pair
   assign byte_latch = req_data.write_byte[7];
   assign wr_ch      = byte_latch ? req_data.write_byte[6:5] : latch_ch_ff;
   assign wr_vol     = byte_latch ? req_data.write_byte[4]   : latch_vol_ff;
   assign wr_data    = req_data.write_byte[5:0];

   // noise countdown saturates at the most negative value before the reload
   assign noise_sub = {noise_cd_ff[15], noise_cd_ff} - $signed(TICK_CYCLES);
   assign noise_sat = (noise_sub[16] != noise_sub[15]) ? 16'sh8000 : noise_sub[15:0];
   assign noise_fire = (noise_sat <= 16'sd0);
   assign lfsr_top  = noise_white_ff ? ^(noise_shift_ff & noise_taps_ff) : noise_shift_ff[0];

   always_comb begin
      case (noise_rate_ff)
         2'd0:    noise_reload = short_noise_ff ? 16'sd16 : 16'sd256;
         2'd1:    noise_reload = short_noise_ff ? 16'sd32 : 16'sd512;
         2'd2:    noise_reload = short_noise_ff ? 16'sd64 : 16'sd1024;
         default: noise_reload = $signed({2'b00, tone_per_ff[2], 4'b0000});
      endcase
   end

   // per-channel tone countdown, independent lanes
   always_comb begin
      for (int i = 0; i < NUM_TONES; i++) begin
         tone_pos[i]  = !tone_cd_ff[i][15] && (tone_cd_ff[i] != 16'sd0);
         tone_run[i]  = tone_pos[i] || (tone_per_ff[i] >= MIN_TONE_RUN);
         tone_dec[i]  = tone_pos[i] ? (tone_cd_ff[i] - 16'sd16) : tone_cd_ff[i];
         tone_load[i] = tone_dec[i] + $signed({2'b00, tone_per_ff[i], 4'b0000});
      end
   end

   // next channel state
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         atten_in[i] = atten_ff[i];
      end
      for (int i = 0; i < NUM_TONES; i++) begin
         tone_per_in[i] = tone_per_ff[i];
         tone_cd_in[i]  = tone_cd_ff[i];
      end
      chan_pol_in    = chan_pol_ff;
      latch_ch_in    = latch_ch_ff;
      latch_vol_in   = latch_vol_ff;
      noise_shift_in = noise_shift_ff;
      noise_white_in = noise_white_ff;
      noise_rate_in  = noise_rate_ff;
      noise_cd_in    = noise_cd_ff;
      noise_tog_in   = noise_tog_ff;
      accum_in       = accum_ff;

      if (req_accept && is_write) begin
         latch_ch_in  = wr_ch;
         latch_vol_in = wr_vol;
         if (wr_vol) begin
            atten_in[wr_ch] = wr_data[3:0];
         end else if (wr_ch != 2'(NOISE_CHANNEL)) begin
            // latch byte sets the low four period bits, data byte the high six
            if (byte_latch) begin
               tone_per_in[wr_ch] = {tone_per_ff[wr_ch][9:4], wr_data[3:0]};
            end else begin
               tone_per_in[wr_ch] = {wr_data, tone_per_ff[wr_ch][3:0]};
            end
         end else begin
            // any noise control write restarts the lfsr
            noise_shift_in = LFSR_SEED;
            noise_rate_in  = wr_data[1:0];
            noise_white_in = wr_data[2];
         end
      end

      if (req_accept && is_tick) begin
         for (int i = 0; i < NUM_TONES; i++) begin
            if (tone_run[i]) begin
               if (tone_dec[i] <= 16'sd0) begin
                  tone_cd_in[i] = tone_load[i];
                  // period one holds a dc level
                  if (tone_per_ff[i] != 10'd1) begin
                     chan_pol_in[i] = !chan_pol_ff[i];
                  end
               end else begin
                  tone_cd_in[i] = tone_dec[i];
               end
            end
         end

         if (noise_fire) begin
            noise_cd_in  = noise_sat + noise_reload;
            noise_tog_in = !noise_tog_ff;
            // shift the lfsr on each rising toggle
            if (!noise_tog_ff) begin
               chan_pol_in[NOISE_CHANNEL] = noise_shift_ff[0];
               noise_shift_in = {lfsr_top, noise_shift_ff[15:1]};
            end
         end else begin
            noise_cd_in = noise_sat;
         end

         accum_in = emit ? (accum_sum - {1'b0, period_eff}) : accum_sum;
      end
   end

   // levels come from the polarity after this tick
   always_comb begin
      rsp_data_in.tone0_level = chan_pol_in[0] ? ~atten_ff[0] : 4'd0;
      rsp_data_in.tone1_level = chan_pol_in[1] ? ~atten_ff[1] : 4'd0;
      rsp_data_in.tone2_level = chan_pol_in[2] ? ~atten_ff[2] : 4'd0;
      rsp_data_in.noise_level = chan_pol_in[NOISE_CHANNEL] ? ~atten_ff[NOISE_CHANNEL] : 4'd0;
   end

   // output register: a new sample replaces one being taken in the same cycle
   always_comb begin
      if (req_accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff <= SAMPLE_PERIOD_RESET;
         short_noise_ff   <= 1'b0;
         noise_taps_ff    <= NOISE_TAPS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_wdata;
            CSR_SHORT_NOISE:   short_noise_ff   <= csr_wdata[0];
            CSR_NOISE_TAPS:    noise_taps_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            atten_ff[i] <= 4'hF;
         end
         for (int i = 0; i < NUM_TONES; i++) begin
            tone_per_ff[i] <= 10'd0;
            tone_cd_ff[i]  <= 16'sd0;
         end
         chan_pol_ff    <= 4'hF;
         latch_ch_ff    <= 2'd0;
         latch_vol_ff   <= 1'b0;
         noise_shift_ff <= LFSR_SEED;
         noise_white_ff <= 1'b0;
         noise_rate_ff  <= 2'd0;
         noise_cd_ff    <= 16'sd0;
         noise_tog_ff   <= 1'b1;
         accum_ff       <= 17'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         atten_ff       <= atten_in;
         tone_per_ff    <= tone_per_in;
         tone_cd_ff     <= tone_cd_in;
         chan_pol_ff    <= chan_pol_in;
         latch_ch_ff    <= latch_ch_in;
         latch_vol_ff   <= latch_vol_in;
         noise_shift_ff <= noise_shift_in;
         noise_white_ff <= noise_white_in;
         noise_rate_ff  <= noise_rate_in;
         noise_cd_ff    <= noise_cd_in;
         noise_tog_ff   <= noise_tog_in;
         accum_ff       <= accum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a write transaction never produces a sample
   `ASSERT_NEXT(a_write_no_rsp, req_valid && req_ready && is_write && !rsp_valid_ff, !rsp_valid_ff)
   // a pending unaccepted sample blocks any tick that would emit another
   `ASSERT_SAME(a_no_overwrite, rsp_valid_ff && !rsp_ready && req_valid && emit, !req_ready)
   // periodic mode rotates the seed, so the lfsr cannot be empty there
   `ASSERT_SAME(a_periodic_nonzero, !noise_white_ff, noise_shift_ff != 16'd0)
   // the pacing accumulator always fits in sixteen bits
   `ASSERT_SAME(a_accum_range, 1'b1, accum_ff[16] == 1'b0)

endmodule
